// ===== rtl/p1305_pkg.sv =====
// Shared types, constants and helpers for the Poly1305 accumulator core.
// Holds the sequencer state type, register indexes, key clamp masks and the
// message block padding function. No dependencies.
`timescale 1ns / 1ps

package p1305_pkg;

    // datapath widths
    localparam int DIG_W   = 32;                 // multiplier operand digit
    localparam int H_DIGS  = 5;                  // digits of the multiplicand
    localparam int R_DIGS  = 4;                  // digits of the clamped key
    localparam int P_DIGS  = 8;                  // digits of the full product
    localparam int ACC_W   = 131;                // partially reduced accumulator
    localparam int SUM_W   = 132;                // block sum and fold result
    localparam int COL_W   = 67;                 // column accumulator
    localparam int BLK_W   = 129;                // padded message block

    // key clamp masks
    localparam logic [63:0] CLAMP_LO = 64'h0FFF_FFFC_0FFF_FFFF;
    localparam logic [63:0] CLAMP_HI = 64'h0FFF_FFFC_0FFF_FFFC;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_R_LOW    = 2'd0,
        REG_R_HIGH   = 2'd1,
        REG_PAD_LOW  = 2'd2,
        REG_PAD_HIGH = 2'd3
    } cfg_idx_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_DRAIN,
        ST_FOLD1,
        ST_FOLD2,
        ST_FIN_FOLD,
        ST_FIN_SUB,
        ST_FIN_OUT
    } state_t;

    // keep the valid bytes and put the 0x01 pad byte right after them
    function automatic logic [BLK_W-1:0] msg_block(
        input logic [127:0] data,
        input logic [4:0]   count
    );
        logic [4:0]       n;
        logic [BLK_W-1:0] pad_bit;
        logic [BLK_W-1:0] mask;
        n       = (count > 5'd16) ? 5'd16 : count;
        pad_bit = BLK_W'(1) << {n, 3'b000};
        mask    = pad_bit - BLK_W'(1);
        return ({1'b0, data} & mask) | pad_bit;
    endfunction

endpackage

// ===== rtl/poly1305_mac_accumulator_core.sv =====
// Poly1305 one-time MAC accumulator core, top level.
// Depends on p1305_pkg (state type, register indexes, clamp masks, padding).
`timescale 1ns / 1ps

// How to use:
// Load key r and pad through the write port (cfg_we, cfg_addr, cfg_data) while
// the core is idle; r is clamped internally. Each slave beat carries one
// message block: data in the low 128 bits, byte count above it, tlast on the
// final block. Non-final blocks carry 16 bytes; an empty message is a single
// final beat with byte count 0.
// A non-empty block passes from acceptance back to ready through a load
// step, the shared 32x32 multiplier (one partial product per cycle, column
// by column), a drain step and a first and a second modular fold.
// A final block adds a fold, a conditional subtract of p and the pad add
// before the tag lands in the master output register. An empty final beat
// takes only those steps.
// A tag waiting in the output register does not block new blocks; only the
// next tag waits while the receiver stalls. Reset clears the key, the pad,
// the accumulator and the output valid.

module poly1305_mac_accumulator_core (
    input  logic         clk,
    input  logic         rst_n,
    // message blocks
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,   // data_low, data_high, byte_count, zero fill
    input  logic         s_axis_tlast,   // last
    // tags
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // tag_low, tag_high
    // configuration writes
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [63:0]  cfg_data
);

    localparam int DW = p1305_pkg::DIG_W;

    // control registers
    p1305_pkg::state_t state_reg, state_next;
    logic [2:0]  col_reg, col_next;
    logic [2:0]  idx_reg, idx_next;
    logic        mul_vld_reg, mul_vld_next;
    logic        mul_end_reg, mul_end_next;
    logic        out_vld_reg, out_vld_next;
    logic        last_reg, last_next;
    logic [63:0] r_low_reg, r_high_reg, pad_low_reg, pad_high_reg;
    logic [p1305_pkg::ACC_W-1:0] acc_reg, acc_next;

    // payload registers
    logic [127:0] data_reg, data_next;
    logic [4:0]   count_reg, count_next;
    logic [p1305_pkg::H_DIGS-1:0][DW-1:0] h_reg, h_next;
    logic [p1305_pkg::P_DIGS-1:0][DW-1:0] prod_reg, prod_next;
    logic [p1305_pkg::SUM_W-1:0] s_reg, s_next;
    logic [2*DW-1:0] mul_p_reg, mul_p_next;
    logic [2:0]      mul_col_reg, mul_col_next;
    logic [p1305_pkg::COL_W-1:0] col_acc_reg, col_acc_next;
    logic [127:0] tag_reg, tag_next;

    // combinational helpers
    logic [p1305_pkg::R_DIGS-1:0][DW-1:0] r_dig;
    logic [1:0]   r_sel;
    logic [2:0]   i_hi;
    logic [2:0]   col_inc;
    logic [2:0]   i_lo_inc;
    logic         col_end;
    logic [2*DW-1:0] mul_p;
    logic [p1305_pkg::COL_W-1:0] col_sum;
    logic [p1305_pkg::P_DIGS*DW-1:0] prod_bits;
    logic [125:0] fold_hi;
    logic [p1305_pkg::SUM_W-1:0] sub_g;
    logic [p1305_pkg::BLK_W-1:0] blk;

    assign s_axis_tready = (state_reg == p1305_pkg::ST_IDLE);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = tag_reg;

    // clamped key split into multiplier digits
    assign r_dig = {r_high_reg & p1305_pkg::CLAMP_HI, r_low_reg & p1305_pkg::CLAMP_LO};

    // column walk of the schoolbook product
    assign r_sel    = 2'(col_reg - idx_reg);
    assign i_hi     = (col_reg < 3'd4) ? col_reg : 3'd4;
    assign col_end  = (idx_reg == i_hi);
    assign col_inc  = col_reg + 3'd1;
    assign i_lo_inc = (col_inc > 3'd3) ? (col_inc - 3'd3) : 3'd0;

    // shared limb multiplier
    assign mul_p = (2*DW)'(h_reg[idx_reg]) * (2*DW)'(r_dig[r_sel]);

    // column accumulation of the registered partial product
    assign col_sum = col_acc_reg + p1305_pkg::COL_W'(mul_p_reg);

    // flat view of the product digits
    assign prod_bits = prod_reg;
    assign fold_hi   = prod_bits[255:130];
    assign sub_g     = s_reg + p1305_pkg::SUM_W'(5);
    assign blk       = p1305_pkg::msg_block(data_reg, count_reg);

    // sequencer and datapath next state
    always_comb
    begin
        state_next   = state_reg;
        col_next     = col_reg;
        idx_next     = idx_reg;
        mul_vld_next = 1'b0;
        mul_end_next = 1'b0;
        mul_col_next = col_reg;
        mul_p_next   = mul_p_reg;
        out_vld_next = out_vld_reg;
        last_next    = last_reg;
        acc_next     = acc_reg;
        data_next    = data_reg;
        count_next   = count_reg;
        h_next       = h_reg;
        prod_next    = prod_reg;
        s_next       = s_reg;
        col_acc_next = col_acc_reg;
        tag_next     = tag_reg;

        // tag leaves the output register
        if (out_vld_reg && m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end

        // partial product lands in its column
        if (mul_vld_reg)
        begin
            if (mul_end_reg)
            begin
                prod_next[mul_col_reg] = col_sum[DW-1:0];
                col_acc_next = p1305_pkg::COL_W'(col_sum[p1305_pkg::COL_W-1:DW]);
            end
            else
            begin
                col_acc_next = col_sum;
            end
        end

        unique case (state_reg)
            p1305_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    data_next  = s_axis_tdata[127:0];
                    count_next = s_axis_tdata[132:128];
                    last_next  = s_axis_tlast;
                    if (s_axis_tdata[132:128] != 5'd0)
                    begin
                        state_next = p1305_pkg::ST_LOAD;
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next = p1305_pkg::ST_FIN_FOLD;
                    end
                end
            end
            p1305_pkg::ST_LOAD:
            begin
                h_next = (p1305_pkg::H_DIGS*DW)'({1'b0, acc_reg}
                                                  + p1305_pkg::SUM_W'(blk));
                col_next     = 3'd0;
                idx_next     = 3'd0;
                col_acc_next = '0;
                state_next   = p1305_pkg::ST_MUL;
            end
            p1305_pkg::ST_MUL:
            begin
                mul_p_next   = mul_p;
                mul_vld_next = 1'b1;
                mul_end_next = col_end;
                mul_col_next = col_reg;
                if (col_end)
                begin
                    if (col_reg == 3'd7)
                    begin
                        state_next = p1305_pkg::ST_DRAIN;
                    end
                    else
                    begin
                        col_next = col_inc;
                        idx_next = i_lo_inc;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            p1305_pkg::ST_DRAIN:
            begin
                state_next = p1305_pkg::ST_FOLD1;
            end
            p1305_pkg::ST_FOLD1:
            begin
                // 2^130 = 5 mod p
                s_next = p1305_pkg::SUM_W'(prod_bits[129:0])
                       + p1305_pkg::SUM_W'({fold_hi, 2'b00})
                       + p1305_pkg::SUM_W'(fold_hi);
                state_next = p1305_pkg::ST_FOLD2;
            end
            p1305_pkg::ST_FOLD2:
            begin
                acc_next = p1305_pkg::ACC_W'(s_reg[129:0])
                         + p1305_pkg::ACC_W'({s_reg[131:130], 2'b00})
                         + p1305_pkg::ACC_W'(s_reg[131:130]);
                state_next = last_reg ? p1305_pkg::ST_FIN_FOLD : p1305_pkg::ST_IDLE;
            end
            p1305_pkg::ST_FIN_FOLD:
            begin
                s_next = p1305_pkg::SUM_W'(acc_reg[129:0])
                       + p1305_pkg::SUM_W'({acc_reg[130], 2'b00})
                       + p1305_pkg::SUM_W'(acc_reg[130]);
                state_next = p1305_pkg::ST_FIN_SUB;
            end
            p1305_pkg::ST_FIN_SUB:
            begin
                // subtract p when value + 5 reaches 2^130
                if (sub_g[130])
                begin
                    s_next = p1305_pkg::SUM_W'(sub_g[129:0]);
                end
                state_next = p1305_pkg::ST_FIN_OUT;
            end
            p1305_pkg::ST_FIN_OUT:
            begin
                if (!out_vld_reg || m_axis_tready)
                begin
                    tag_next     = s_reg[127:0] + {pad_high_reg, pad_low_reg};
                    out_vld_next = 1'b1;
                    acc_next     = '0;
                    state_next   = p1305_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = p1305_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= p1305_pkg::ST_IDLE;
            col_reg     <= 3'd0;
            idx_reg     <= 3'd0;
            mul_vld_reg <= 1'b0;
            mul_end_reg <= 1'b0;
            out_vld_reg <= 1'b0;
            last_reg    <= 1'b0;
            acc_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            idx_reg     <= idx_next;
            mul_vld_reg <= mul_vld_next;
            mul_end_reg <= mul_end_next;
            out_vld_reg <= out_vld_next;
            last_reg    <= last_next;
            acc_reg     <= acc_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_low_reg    <= '0;
            r_high_reg   <= '0;
            pad_low_reg  <= '0;
            pad_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (p1305_pkg::cfg_idx_t'(cfg_addr))
                p1305_pkg::REG_R_LOW:    r_low_reg    <= cfg_data;
                p1305_pkg::REG_R_HIGH:   r_high_reg   <= cfg_data;
                p1305_pkg::REG_PAD_LOW:  pad_low_reg  <= cfg_data;
                p1305_pkg::REG_PAD_HIGH: pad_high_reg <= cfg_data;
                default:                 r_low_reg    <= r_low_reg;
            endcase
        end
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        data_reg    <= data_next;
        count_reg   <= count_next;
        h_reg       <= h_next;
        prod_reg    <= prod_next;
        s_reg       <= s_next;
        mul_p_reg   <= mul_p_next;
        mul_col_reg <= mul_col_next;
        col_acc_reg <= col_acc_next;
        tag_reg     <= tag_next;
    end

    // multiplier walk stays inside the digit grid
    a_mul_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == p1305_pkg::ST_MUL) |->
            (idx_reg <= col_reg) && (idx_reg <= 3'd4)
            && (({1'b0, idx_reg} + 4'd3) >= {1'b0, col_reg}))
        else $error("multiplier digit walk out of range");

    // no partial product still in flight when the fold reads the product
    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == p1305_pkg::ST_FOLD1) |-> !mul_vld_reg)
        else $error("product folded before last column settled");

    // second fold leaves the accumulator just above 2^130 at most
    a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == p1305_pkg::ST_FOLD2) |=>
            (!acc_reg[130] || (acc_reg[129:4] == '0)))
        else $error("accumulator not partially reduced");

    // value handed to the pad add is fully reduced
    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == p1305_pkg::ST_FIN_OUT) |->
            (s_reg[131:130] == 2'b00)
            && !((s_reg[129:3] == {127{1'b1}}) && (s_reg[2:0] >= 3'd3)))
        else $error("tag value not reduced below p");

    // a stalled tag holds back the next one
    a_tag_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == p1305_pkg::ST_FIN_OUT && out_vld_reg && !m_axis_tready) |=>
            (state_reg == p1305_pkg::ST_FIN_OUT) && $stable(tag_reg))
        else $error("pending tag overwritten");

endmodule
